// ===== hw/rtl/radial_shooting_recurrence_core_assert.svh =====
// Assertion macros for the radial shooting recurrence core.
// Used by the top level; expects signals clk and rst in scope.
`ifndef RADIAL_SHOOTING_RECURRENCE_CORE_ASSERT_SVH
`define RADIAL_SHOOTING_RECURRENCE_CORE_ASSERT_SVH

// Same-cycle implication
`define RSR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsr assertion failed");

// Next-cycle implication
`define RSR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsr assertion failed");

`endif

// ===== hw/rtl/rsr_pkg.sv =====
// Package for the radial shooting recurrence core: formats, limits, codes, types.
// No dependencies.
`timescale 1ns / 1ps
package rsr_pkg;

  localparam int SAMPLE_FRAC_BITS = 16;
  localparam int PSI_FRAC_BITS    = 32;
  localparam int GAIN_FRAC_BITS   = 31;

  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // saturation bounds on magnitudes
  localparam logic [63:0] LIM_VAL = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] LIM_MID = 64'd1 << 40;
  localparam logic [63:0] LIM_BIG = 64'd1 << 62;
  localparam logic [63:0] LIM_PSI = (64'd1 << 47) - 64'd1;

  localparam logic signed [47:0] PSI_ONE = 48'(64'd1 << PSI_FRAC_BITS);
  localparam logic [30:0] ONE_S = 31'(64'd1 << SAMPLE_FRAC_BITS);

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRIAL_ENERGY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KINETIC_COEFF = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NONPARABOLIC  = 2'd3;

  // sample kinds decided by the front end
  localparam logic [1:0] KIND_INIT = 2'd0;  // starts a sweep
  localparam logic [1:0] KIND_SOLO = 2'd1;  // starts and ends a sweep
  localparam logic [1:0] KIND_STEP = 2'd2;  // runs the recurrence
  localparam logic [1:0] KIND_END  = 2'd3;  // ends a sweep, emits

  typedef struct packed {
    logic signed [31:0] trial_energy;
    logic [30:0]        step_size;
    logic [30:0]        kinetic_coeff;
    logic               nonparabolic;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [30:0]        radius;
    logic signed [31:0] potential;
    logic [30:0]        mass;
    logic [30:0]        band_edge_mass;
    logic [30:0]        band_param;
  } item_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
  } fe_stat_t;

  typedef struct packed {
    logic idle;
    logic pop;
    logic mul_busy;
    logic div_busy;
  } bk_stat_t;

endpackage

// ===== hw/rtl/rsr_in_if.sv =====
// Sample channel: valid/ready with one radial sample.
// No dependencies.
`timescale 1ns / 1ps
interface rsr_in_if;
  logic               valid;
  logic               ready;
  logic [30:0]        radius;
  logic signed [31:0] potential;
  logic [30:0]        mass;
  logic [30:0]        band_edge_mass;
  logic [30:0]        band_param;
  logic               first;
  logic               last;

  modport source (output valid, radius, potential, mass, band_edge_mass, band_param,
                  first, last, input ready);
  modport sink (input valid, radius, potential, mass, band_edge_mass, band_param,
                first, last, output ready);
endinterface

// ===== hw/rtl/rsr_out_if.sv =====
// Result channel: valid/ready with end wavefunction and saturation flag.
// No dependencies.
`timescale 1ns / 1ps
interface rsr_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] psi_end;
  logic               saturated;

  modport source (output valid, psi_end, saturated, input ready);
  modport sink (input valid, psi_end, saturated, output ready);
endinterface

// ===== hw/rtl/radial_shooting_recurrence_core.sv =====
// Radial shooting recurrence core. A first or last sample is handled in the idle state;
// a middle sample runs a divider pass for the ratio and five multiplies on the shared
// 32x32 multiplier, and in non-parabolic mode a second divider pass and three more
// multiplies. Samples queue two deep ahead.
// Synchronous active-high reset clears sweep state, queue and config to defaults.
`timescale 1ns / 1ps
`include "radial_shooting_recurrence_core_assert.svh"
module radial_shooting_recurrence_core
  import rsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rsr_in_if.sink                samples,
  rsr_out_if.source             results
);

  cfg_t     cfg;
  logic     q_valid, q_pop;
  item_t    q_item;
  fe_stat_t fe_stat;
  bk_stat_t bk_stat;
  logic     pop_emit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trial_energy  <= '0;
      cfg.step_size     <= ONE_S;
      cfg.kinetic_coeff <= ONE_S;
      cfg.nonparabolic  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRIAL_ENERGY:  cfg.trial_energy  <= $signed(cfg_data);
        CFG_STEP_SIZE:     cfg.step_size     <= cfg_data[30:0];
        CFG_KINETIC_COEFF: cfg.kinetic_coeff <= cfg_data[30:0];
        CFG_NONPARABOLIC:  cfg.nonparabolic  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rsr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .fe_stat (fe_stat)
  );

  rsr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .results (results),
    .bk_stat (bk_stat)
  );

  // a popped sweep end loads the result register
  assign pop_emit = bk_stat.pop && (q_item.kind == KIND_SOLO || q_item.kind == KIND_END);

  `RSR_ASSERT_IMP(a_queue_bound, 1'b1, fe_stat.count <= Q_CNT_W'(Q_DEPTH))
  `RSR_ASSERT_IMP(a_one_unit, 1'b1, !(bk_stat.mul_busy && bk_stat.div_busy))
  `RSR_ASSERT_IMP(a_pop_idle, bk_stat.pop, bk_stat.idle && fe_stat.count != '0)
  `RSR_ASSERT_NXT(a_emit, pop_emit, results.valid)

endmodule

// ===== hw/rtl/rsr_mul.sv =====
// Signed multiply, shift and saturate on one 32x32 multiplier over four partial products.
// Depends on rsr_pkg.
`timescale 1ns / 1ps
module rsr_mul
  import rsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] x,
  input  logic signed [63:0] y,
  input  logic               sh_long,
  input  logic [63:0]        lim,
  output logic               busy,
  output logic               done,
  output logic signed [63:0] res,
  output logic               sat
);

  logic [2:0]   cnt;
  logic [63:0]  ux, uy, bound;
  logic         neg, shl;
  logic [63:0]  pp;
  logic [1:0]   pp_idx;
  logic [127:0] acc;
  logic [31:0]  xh, yh;
  logic [127:0] pp_shifted, shifted;
  logic [63:0]  mag_res;
  logic         over;

  // operand halves for the current partial product
  always_comb begin
    xh = cnt[0] ? ux[63:32] : ux[31:0];
    yh = cnt[1] ? uy[63:32] : uy[31:0];
    case (pp_idx)
      2'd0:    pp_shifted = {64'd0, pp};
      2'd3:    pp_shifted = {pp, 64'd0};
      default: pp_shifted = {32'd0, pp, 32'd0};
    endcase
    shifted = shl ? (acc >> GAIN_FRAC_BITS) : (acc >> SAMPLE_FRAC_BITS);
    over    = shifted > {64'd0, bound};
    mag_res = over ? bound : shifted[63:0];
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      ux    <= x[63] ? 64'(-x) : 64'(x);
      uy    <= y[63] ? 64'(-y) : 64'(y);
      neg   <= x[63] ^ y[63];
      bound <= lim + {63'd0, x[63] ^ y[63]};
      shl   <= sh_long;
      acc   <= '0;
      cnt   <= '0;
      busy  <= 1'b1;
    end else if (busy) begin
      cnt <= cnt + 3'd1;
      if (cnt <= 3'd3) begin
        pp     <= xh * yh;
        pp_idx <= cnt[1:0];
      end
      if (cnt >= 3'd1 && cnt <= 3'd4) begin
        acc <= acc + pp_shifted;
      end
      if (cnt == 3'd5) begin
        res  <= neg ? $signed(-mag_res) : $signed(mag_res);
        sat  <= over;
        done <= 1'b1;
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/rsr_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend, 33-bit divisor.
// Depends on rsr_pkg.
`timescale 1ns / 1ps
module rsr_div
  import rsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [63:0] quo
);

  localparam int DIV_STEPS = 64;
  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [CNT_W-1:0] cnt;
  logic [63:0]      dvd;
  logic [32:0]      rem, dsr;
  logic [33:0]      trial, diff;
  logic             ge;

  // one trial subtraction
  always_comb begin
    trial = {rem, dvd[63]};
    ge    = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  assign quo = dvd;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      dvd  <= dividend;
      dsr  <= divisor;
      rem  <= '0;
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      rem <= ge ? diff[32:0] : trial[32:0];
      dvd <= {dvd[62:0], ge};
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/rsr_front.sv =====
// Front end: accepts samples, tracks sweep position, classifies and queues them.
// Depends on rsr_pkg and rsr_in_if.
`timescale 1ns / 1ps
module rsr_front
  import rsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  rsr_in_if.sink    samples,
  output logic      q_valid,
  output item_t     q_item,
  input  logic      q_pop,
  output fe_stat_t  fe_stat
);

  item_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               past_first;
  logic               accept, starting;
  item_t              wr_item;

  assign samples.ready = count != Q_CNT_W'(Q_DEPTH);
  assign accept        = samples.valid && samples.ready;
  assign q_valid       = count != '0;
  assign q_item        = mem[rd_ptr];
  assign fe_stat.count = count;

  // classify the incoming sample
  always_comb begin
    starting               = samples.first || !past_first;
    wr_item.radius         = samples.radius;
    wr_item.potential      = samples.potential;
    wr_item.mass           = samples.mass;
    wr_item.band_edge_mass = samples.band_edge_mass;
    wr_item.band_param     = samples.band_param;
    if (starting) begin
      wr_item.kind = samples.last ? KIND_SOLO : KIND_INIT;
    end else begin
      wr_item.kind = samples.last ? KIND_END : KIND_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  // queue pointers and sweep tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
      past_first <= 1'b0;
    end else begin
      if (accept) begin
        wr_ptr     <= wr_ptr + 1'b1;
        past_first <= !samples.last;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (accept && !q_pop) begin
        count <= count + 1'b1;
      end else if (!accept && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/rsr_back.sv =====
// Back end: sequences the recurrence for one queued sample and holds the result register.
// Depends on rsr_pkg, rsr_out_if, rsr_mul and rsr_div.
`timescale 1ns / 1ps
module rsr_back
  import rsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  item_t     q_item,
  output logic      q_pop,
  rsr_out_if.source results,
  output bk_stat_t  bk_stat
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV_G = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_ALPHA = 4'd3;
  localparam logic [3:0] S_P     = 4'd4;
  localparam logic [3:0] S_M     = 4'd5;
  localparam logic [3:0] S_MK    = 4'd6;
  localparam logic [3:0] S_T     = 4'd7;
  localparam logic [3:0] S_A     = 4'd8;
  localparam logic [3:0] S_T1    = 4'd9;
  localparam logic [3:0] S_T2    = 4'd10;
  localparam logic [3:0] S_SUM   = 4'd11;

  logic [3:0]         state;
  logic               issued;
  item_t              cur;
  logic [30:0]        g;
  logic signed [32:0] h;
  logic [45:0]        sq;
  logic [61:0]        alpha;
  logic signed [41:0] p;
  logic signed [31:0] m, mk, c;
  logic signed [47:0] a, t1, t2;
  logic signed [47:0] psi_prev, psi_cur, psi_latest;
  logic               sat_seen;
  logic               out_valid, out_sat;
  logic signed [47:0] out_psi;

  logic               mul_start, mul_busy, mul_done, mul_sat, mul_long;
  logic signed [63:0] mul_x, mul_y, mul_res;
  logic [63:0]        mul_lim;
  logic               div_start, div_busy, div_done;
  logic [63:0]        div_dvd, div_quo;
  logic [32:0]        div_dsr;

  logic               can_emit, is_div_state, is_mul_state;
  logic [31:0]        r2;
  logic [30:0]        dz, bb;
  logic signed [32:0] om, ev, ve;
  logic signed [42:0] onep;
  logic signed [31:0] m_eff;
  logic signed [43:0] cw;
  logic               c_ovf;
  logic signed [48:0] sum;
  logic               sum_ovf;

  assign results.valid     = out_valid;
  assign results.psi_end   = out_psi;
  assign results.saturated = out_sat;

  assign can_emit = !out_valid || results.ready;
  assign q_pop    = (state == S_IDLE) && q_valid &&
                    (can_emit || q_item.kind == KIND_INIT || q_item.kind == KIND_STEP);

  assign bk_stat.idle     = state == S_IDLE;
  assign bk_stat.pop      = q_pop;
  assign bk_stat.mul_busy = mul_busy;
  assign bk_stat.div_busy = div_busy;

  // operand preparation
  always_comb begin
    r2     = {cur.radius, 1'b0};
    dz     = (cfg.step_size == '0) ? 31'd1 : cfg.step_size;
    bb     = (cur.band_param == '0) ? 31'd1 : cur.band_param;
    om     = $signed({2'b00, ONE_S}) - $signed({2'b00, cur.band_edge_mass});
    ev     = 33'(cfg.trial_energy) - 33'(cur.potential);
    ve     = 33'(cur.potential) - 33'(cfg.trial_energy);
    onep   = 43'(p) + $signed({12'd0, ONE_S});
    m_eff  = cfg.nonparabolic ? m : $signed({1'b0, cur.mass});
    cw     = $signed({mul_res[41], mul_res[41:0], 1'b0}) + $signed({12'd0, ONE_S, 1'b0});
    c_ovf  = !((&cw[43:31]) || !(|cw[43:31]));
    sum    = 49'(t1) + 49'(t2);
    sum_ovf = sum[48] != sum[47];
    is_div_state = (state == S_DIV_G) || (state == S_ALPHA);
    is_mul_state = (state == S_SQ) || (state == S_P) || (state == S_M) || (state == S_MK) ||
                   (state == S_T) || (state == S_A) || (state == S_T1) || (state == S_T2);
    mul_start = is_mul_state && !issued;
    div_start = is_div_state && !issued;
  end

  // divider operand select
  always_comb begin
    if (state == S_ALPHA) begin
      div_dvd = {2'b00, sq, 16'd0};
      div_dsr = {2'b00, bb};
    end else begin
      div_dvd = {1'b0, r2, 31'd0};
      div_dsr = {1'b0, r2} + {2'b00, dz};
    end
  end

  // multiplier operand select
  always_comb begin
    mul_x    = 64'(om);
    mul_y    = 64'(om);
    mul_lim  = LIM_BIG;
    mul_long = 1'b0;
    unique case (state)
      S_P: begin
        mul_x   = $signed({2'b00, alpha});
        mul_y   = 64'(ev);
        mul_lim = LIM_MID;
      end
      S_M: begin
        mul_x   = $signed({33'd0, cur.band_edge_mass});
        mul_y   = 64'(onep);
        mul_lim = LIM_VAL;
      end
      S_MK: begin
        mul_x   = 64'(m_eff);
        mul_y   = $signed({33'd0, cfg.kinetic_coeff});
        mul_lim = LIM_VAL;
      end
      S_T: begin
        mul_x   = 64'(mk);
        mul_y   = 64'(ve);
        mul_lim = LIM_MID;
      end
      S_A: begin
        mul_x   = $signed({33'd0, g});
        mul_y   = 64'(c);
      end
      S_T1: begin
        mul_x    = 64'(a);
        mul_y    = 64'(psi_cur);
        mul_lim  = LIM_PSI;
        mul_long = 1'b1;
      end
      S_T2: begin
        mul_x    = 64'(h);
        mul_y    = 64'(psi_prev);
        mul_lim  = LIM_PSI;
        mul_long = 1'b1;
      end
      default: begin
        mul_x = 64'(om);
      end
    endcase
  end

  rsr_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .x       (mul_x),
    .y       (mul_y),
    .sh_long (mul_long),
    .lim     (mul_lim),
    .busy    (mul_busy),
    .done    (mul_done),
    .res     (mul_res),
    .sat     (mul_sat)
  );

  rsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .done     (div_done),
    .quo      (div_quo)
  );

  // sequencer, sweep state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issued     <= 1'b0;
      out_valid  <= 1'b0;
      psi_prev   <= PSI_ONE;
      psi_cur    <= PSI_ONE;
      psi_latest <= '0;
      sat_seen   <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      if (mul_start || div_start) begin
        issued <= 1'b1;
      end
      if (mul_done && mul_sat) begin
        sat_seen <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            cur <= q_item;
            if (q_item.kind == KIND_STEP) begin
              state <= S_DIV_G;
            end else begin
              if (q_item.kind == KIND_END) begin
                out_valid <= 1'b1;
                out_psi   <= psi_latest;
                out_sat   <= sat_seen;
              end else if (q_item.kind == KIND_SOLO) begin
                out_valid <= 1'b1;
                out_psi   <= '0;
                out_sat   <= 1'b0;
              end
              psi_prev   <= PSI_ONE;
              psi_cur    <= PSI_ONE;
              psi_latest <= '0;
              sat_seen   <= 1'b0;
            end
          end
        end
        S_DIV_G: begin
          if (div_done) begin
            issued <= 1'b0;
            g      <= div_quo[30:0];
            h      <= $signed({2'b01, 31'd0}) - $signed({1'b0, div_quo[30:0], 1'b0});
            state  <= cfg.nonparabolic ? S_SQ : S_MK;
          end
        end
        S_SQ: begin
          if (mul_done) begin
            issued <= 1'b0;
            sq     <= mul_res[45:0];
            state  <= S_ALPHA;
          end
        end
        S_ALPHA: begin
          if (div_done) begin
            issued <= 1'b0;
            alpha  <= div_quo[61:0];
            state  <= S_P;
          end
        end
        S_P: begin
          if (mul_done) begin
            issued <= 1'b0;
            p      <= mul_res[41:0];
            state  <= S_M;
          end
        end
        S_M: begin
          if (mul_done) begin
            issued <= 1'b0;
            m      <= mul_res[31:0];
            state  <= S_MK;
          end
        end
        S_MK: begin
          if (mul_done) begin
            issued <= 1'b0;
            mk     <= mul_res[31:0];
            state  <= S_T;
          end
        end
        S_T: begin
          if (mul_done) begin
            issued <= 1'b0;
            // c = 2t + 2, clamped to 32 bits
            if (c_ovf) begin
              c        <= cw[43] ? $signed(32'h8000_0000) : $signed(32'h7FFF_FFFF);
              sat_seen <= 1'b1;
            end else begin
              c <= cw[31:0];
            end
            state <= S_A;
          end
        end
        S_A: begin
          if (mul_done) begin
            issued <= 1'b0;
            a      <= mul_res[47:0];
            state  <= S_T1;
          end
        end
        S_T1: begin
          if (mul_done) begin
            issued <= 1'b0;
            t1     <= mul_res[47:0];
            state  <= S_T2;
          end
        end
        S_T2: begin
          if (mul_done) begin
            issued <= 1'b0;
            t2     <= mul_res[47:0];
            state  <= S_SUM;
          end
        end
        S_SUM: begin
          psi_prev <= psi_cur;
          if (sum_ovf) begin
            psi_cur    <= sum[48] ? $signed({1'b1, 47'd0}) : $signed({1'b0, {47{1'b1}}});
            psi_latest <= sum[48] ? $signed({1'b1, 47'd0}) : $signed({1'b0, {47{1'b1}}});
            sat_seen   <= 1'b1;
          end else begin
            psi_cur    <= sum[47:0];
            psi_latest <= sum[47:0];
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
